### rtl/afp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afp_pkg: shared types and constants for the adaptive frame pacer
// Sequencer states, command and action codes, divider status, fixed constants.
// ----------------------------------------------------------------------------
package afp_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned PendW    = 10;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_PERIOD = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TICK   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RTM    = 2'd2;

  // shared divider geometry
  localparam int unsigned DivW     = 32;
  localparam int unsigned DivisorW = 8;

  // interval adaptation constants (percent math, round half up)
  localparam int unsigned RelaxNum = 105;
  localparam int unsigned TightNum = 96;
  localparam int unsigned PctRound = 50;
  localparam logic [7:0]  DropMax  = 8'd200;
  localparam logic [7:0]  DropMin  = 8'd3;
  localparam logic [3:0]  QuietLim = 4'd8;
  localparam logic [9:0]  BacklogLim = 10'd2;
  localparam logic signed [31:0] SlackMin = -32'sd127;

  // x / 100 as (x * 5243) >> 19, exact for any 15-bit x
  localparam int unsigned PctNumW    = 15;
  localparam logic [12:0] RecipMul   = 13'd5243;
  localparam int unsigned RecipShift = 19;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_SLOT = 2'd1,
    CMD_DROP = 2'd2
  } afp_cmd_e;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_RENDER = 2'd1,
    ACT_SKIP   = 2'd2
  } afp_action_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK_ADD,
    S_TICK_CHK,
    S_SLOT,
    S_RELAX,
    S_RELAX_SET,
    S_SKIP_CHK,
    S_MOD,
    S_DROP,
    S_DROP_WAIT,
    S_DROP_SET,
    S_DONE
  } afp_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // -256 * round_half_up(period / 256)
  function automatic logic [31:0] init_slack(input logic [15:0] period);
    logic [16:0] sum;
    logic [31:0] rounded;
    sum     = {1'b0, period} + 17'd128;
    rounded = {15'b0, sum[16:8], 8'b0};
    return 32'd0 - rounded;
  endfunction

endpackage

### rtl/afp_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afp_in_if: event channel into the frame pacer
// Valid/ready handshake carrying one command per transaction.
// ----------------------------------------------------------------------------
interface afp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [6:0] drop_percent;

  modport source (output valid, output command, output drop_percent, input ready);
  modport sink   (input valid, input command, input drop_percent, output ready);
endinterface

### rtl/afp_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afp_out_if: result channel out of the frame pacer
// Valid/ready handshake carrying one decision per transaction.
// ----------------------------------------------------------------------------
interface afp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic       frame_due;
  logic [9:0] backlog_seen;
  logic [7:0] drop_interval_now;

  modport source (output valid, output action, output frame_due, output backlog_seen,
                  output drop_interval_now, input ready);
  modport sink   (input valid, input action, input frame_due, input backlog_seen,
                  input drop_interval_now, output ready);
endinterface

### rtl/afp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afp_div: shared restoring divider
// One quotient bit per cycle; remainder of a 32-bit dividend by an 8-bit
// nonzero divisor.
// ----------------------------------------------------------------------------
module afp_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [afp_pkg::DivW-1:0]            dividend_i,
  input  logic [afp_pkg::DivisorW-1:0]        divisor_i,
  output afp_pkg::div_stat_t                  stat_o,
  output logic [afp_pkg::DivisorW-1:0]        rem_o
);
  import afp_pkg::*;

  localparam int unsigned CntW = $clog2(DivW);

  logic [DivW-1:0]     dvd_q, dvd_d;
  logic [DivisorW-1:0] dsr_q, dsr_d;
  logic [DivisorW-1:0] rem_q, rem_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;

  logic [DivisorW:0] part;
  logic [DivisorW:0] diff;
  logic              fits;

  assign part = {rem_q, dvd_q[DivW-1]};
  assign diff = part - {1'b0, dsr_q};
  assign fits = part >= {1'b0, dsr_q};

  always_comb begin
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? diff[DivisorW-1:0] : part[DivisorW-1:0];
      dvd_d = {dvd_q[DivW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign rem_o       = rem_q;

endmodule

### rtl/adaptive_frame_pacer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_frame_pacer_unit: frame pacing and render/skip decisions
// Sequencer around one shared restoring divider; one result per command.
// ----------------------------------------------------------------------------
// The pacer takes one command transaction at a time and returns exactly one
// result transaction for it. Every command runs accept first and hand-off
// last, until the next command can be taken with the output register free.
// Between them a timer tick runs saturating add and deadline check; a tick
// outside real-time mode or the spare command runs nothing. A drop request
// runs an update, plus scale and apply steps for the percent scaling x / 100
// (a reciprocal multiply) when the interval is tightened. A render slot runs
// a slot check; unless nothing is pending it adds relax and relax-set steps
// when it relaxes the interval, then a skip check, then a modulo wait when it
// tests the periodic skip: rendered_count modulo the interval runs on the
// shared divider, one quotient bit per cycle. Input ready is high only while
// the sequencer is idle; a finished result sits in the output register, so a
// new command is taken while the previous result still waits, and a result
// stalls in hand-off only while the one before it is still unaccepted.
// Configuration writes go straight to the registers; writing the frame period
// reloads the deadline slack and clears the rendered count.
// ----------------------------------------------------------------------------
module adaptive_frame_pacer_unit #(
  parameter int unsigned MAX_PENDING = 1000
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  afp_in_if.sink                        in_i,
  afp_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [afp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [afp_pkg::CfgDataW-1:0]  cfg_data_i
);
  import afp_pkg::*;

  localparam logic [PendW-1:0] MaxPend = PendW'(MAX_PENDING);

  // sequencer and command context
  afp_state_e  state_q, state_d;
  logic [6:0]  pct_q, pct_d;
  afp_action_e act_q, act_d;
  logic        due_q, due_d;

  // configuration
  logic [15:0] period_q, period_d;
  logic [7:0]  tick_q, tick_d;
  logic        rtm_q, rtm_d;

  // pacing state
  logic [31:0]      slack_q, slack_d;
  logic [PendW-1:0] pend_q, pend_d;
  logic [PendW-1:0] backlog_q, backlog_d;
  logic [31:0]      rend_q, rend_d;
  logic [7:0]       di_q, di_d;
  logic [3:0]       quiet_q, quiet_d;

  // percent scaling: numerator, then quotient
  logic [PctNumW-1:0] num_q, num_d;
  logic [7:0]         quot_q, quot_d;

  // output register
  logic             out_valid_q, out_valid_d;
  logic [1:0]       out_act_q;
  logic             out_due_q;
  logic [PendW-1:0] out_backlog_q;
  logic [7:0]       out_di_q;
  logic             load_out;

  // shared divider
  logic                div_start;
  logic [DivW-1:0]     div_dvd;
  logic [DivisorW-1:0] div_dsr;
  div_stat_t           div_stat;
  logic [DivisorW-1:0] div_rem;

  // datapath helpers
  logic [32:0] tick_sum;
  logic [31:0] tick_sat;
  logic [3:0]  quiet_inc;
  logic [27:0] recip_prod;
  logic [8:0]  relaxed_adj;
  logic        skip;

  afp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .stat_o     (div_stat),
    .rem_o      (div_rem)
  );

  // slack + tick*256, clamped at the largest positive value
  assign tick_sum  = {slack_q[31], slack_q} + {17'b0, tick_q, 8'b0};
  assign tick_sat  = (!tick_sum[32] && tick_sum[31]) ? 32'h7FFF_FFFF : tick_sum[31:0];
  assign quiet_inc = quiet_q + 4'd1;

  // num / 100 by reciprocal multiply
  assign recip_prod = {13'b0, num_q} * {15'b0, RecipMul};

  // relax: bump by one if 5% rounds to no change
  assign relaxed_adj = (quot_q == di_q) ? {1'b0, quot_q} + 9'd1 : {1'b0, quot_q};

  assign in_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    pct_d     = pct_q;
    act_d     = act_q;
    due_d     = due_q;
    period_d  = period_q;
    tick_d    = tick_q;
    rtm_d     = rtm_q;
    slack_d   = slack_q;
    pend_d    = pend_q;
    backlog_d = backlog_q;
    rend_d    = rend_q;
    di_d      = di_q;
    quiet_d   = quiet_q;
    num_d     = num_q;
    quot_d    = quot_q;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dsr   = '0;
    load_out  = 1'b0;
    skip      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          pct_d = in_i.drop_percent;
          act_d = ACT_NONE;
          due_d = 1'b0;
          case (afp_cmd_e'(in_i.command))
            CMD_TICK: state_d = rtm_q ? S_TICK_ADD : S_DONE;
            CMD_SLOT: state_d = S_SLOT;
            CMD_DROP: state_d = S_DROP;
            default:  state_d = S_DONE;
          endcase
        end
      end

      S_TICK_ADD: begin
        slack_d = tick_sat;
        state_d = S_TICK_CHK;
      end

      S_TICK_CHK: begin
        // deadline reached once slack climbs to within half a ms
        if ($signed(slack_q) >= SlackMin) begin
          slack_d   = slack_q - {16'b0, period_q};
          backlog_d = pend_q;
          if (pend_q < MaxPend) begin
            pend_d = pend_q + 1'b1;
          end
          due_d = 1'b1;
        end
        state_d = S_DONE;
      end

      S_SLOT: begin
        if (rtm_q && (pend_q == '0)) begin
          state_d = S_DONE;
        end else begin
          if (rtm_q) begin
            pend_d = pend_q - 1'b1;
          end
          quiet_d = quiet_inc;
          if ((quiet_inc >= QuietLim) && (di_q != '0)) begin
            num_d   = {7'b0, di_q} * PctNumW'(RelaxNum) + PctNumW'(PctRound);
            state_d = S_RELAX;
          end else begin
            state_d = S_SKIP_CHK;
          end
        end
      end

      S_RELAX: begin
        quot_d  = recip_prod[RecipShift +: 8];
        state_d = S_RELAX_SET;
      end

      S_RELAX_SET: begin
        di_d    = (relaxed_adj > {1'b0, DropMax}) ? 8'd0 : relaxed_adj[7:0];
        quiet_d = '0;
        state_d = S_SKIP_CHK;
      end

      S_SKIP_CHK: begin
        if (backlog_q > BacklogLim) begin
          skip    = 1'b1;
          act_d   = (skip && rtm_q) ? ACT_SKIP : ACT_RENDER;
          state_d = S_DONE;
        end else if (di_q != '0) begin
          div_start = 1'b1;
          div_dvd   = rend_q;
          div_dsr   = di_q;
          state_d   = S_MOD;
        end else begin
          rend_d  = rend_q + 32'd1;
          act_d   = ACT_RENDER;
          state_d = S_DONE;
        end
      end

      S_MOD: begin
        if (div_stat.done) begin
          // periodic skip at the end and the middle of each interval
          skip    = (div_rem == di_q - 8'd1) || (div_rem == (di_q >> 1));
          rend_d  = rend_q + 32'd1;
          act_d   = (skip && rtm_q) ? ACT_SKIP : ACT_RENDER;
          state_d = S_DONE;
        end
      end

      S_DROP: begin
        state_d = S_DONE;
        if (pct_q != '0) begin
          quiet_d = '0;
          if (di_q == '0) begin
            di_d = DropMax;
          end else if (di_q > DropMin) begin
            num_d   = {7'b0, di_q} * PctNumW'(TightNum) + PctNumW'(PctRound);
            state_d = S_DROP_WAIT;
          end
        end
      end

      S_DROP_WAIT: begin
        quot_d  = recip_prod[RecipShift +: 8];
        state_d = S_DROP_SET;
      end

      S_DROP_SET: begin
        di_d    = (quot_q < DropMin) ? DropMin : quot_q;
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // the user must make config land only while idle; the block does not enforce it
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PERIOD: begin
          period_d = cfg_data_i;
          slack_d  = init_slack(cfg_data_i);
          rend_d   = '0;
        end
        CFG_TICK: tick_d = cfg_data_i[7:0];
        CFG_RTM:  rtm_d  = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pct_q       <= '0;
      act_q       <= ACT_NONE;
      due_q       <= 1'b0;
      period_q    <= 16'd10240;
      tick_q      <= 8'd1;
      rtm_q       <= 1'b1;
      slack_q     <= init_slack(16'd10240);
      pend_q      <= '0;
      backlog_q   <= '0;
      rend_q      <= '0;
      di_q        <= '0;
      quiet_q     <= '0;
      num_q       <= '0;
      quot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pct_q       <= pct_d;
      act_q       <= act_d;
      due_q       <= due_d;
      period_q    <= period_d;
      tick_q      <= tick_d;
      rtm_q       <= rtm_d;
      slack_q     <= slack_d;
      pend_q      <= pend_d;
      backlog_q   <= backlog_d;
      rend_q      <= rend_d;
      di_q        <= di_d;
      quiet_q     <= quiet_d;
      num_q       <= num_d;
      quot_q      <= quot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_act_q     <= act_q;
      out_due_q     <= due_q;
      out_backlog_q <= backlog_q;
      out_di_q      <= di_q;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.action            = out_act_q;
  assign out_o.frame_due         = out_due_q;
  assign out_o.backlog_seen      = out_backlog_q;
  assign out_o.drop_interval_now = out_di_q;

  // pending frame count never grows past the cap
  a_pend_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= MaxPend)
    else $error("pending frame count above cap");

  // interval is off or within its working range
  a_di_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (di_q == '0) || ((di_q >= DropMin) && (di_q <= DropMax)))
    else $error("drop interval out of range");

  // divider results only arrive while the sequencer waits for the modulo
  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == S_MOD))
    else $error("divider finished with no consumer");

  // a deadline result never carries a render decision
  a_due_no_act: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out && due_q |-> act_q == ACT_NONE)
    else $error("frame due together with render action");

  // a divider pass is never started while one is running
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for adaptive_frame_pacer_unit
// Drives tick, render-slot and drop-request transactions under random source
// gaps and sink stalls. Each accepted command is run through an in-bench
// pacing predictor, and every result transaction is checked field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import afp_pkg::*;

  // ---------------------------------------------------------------------------
  // Bench constants
  // ---------------------------------------------------------------------------
  localparam int unsigned MAX_PENDING  = 1000;
  localparam int unsigned RUN_LIMIT    = 2_000_000; // cycles before we give up
  localparam int unsigned SETTLE_WAIT  = 80;        // > slowest slot
  localparam int unsigned SOAK_TICKS   = 64;        // a deadline on every tick
  localparam int unsigned QUEUE_DEPTH  = 8;         // keep the feed short

  // Codes the package does not name: the spare command and the spare register
  localparam logic [1:0]         CMD_SPARE = 2'd3;
  localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0] cmd;
    logic [6:0] pct;
  } pacer_cmd_t;

  typedef struct packed {
    afp_action_e action;
    logic        frame_due;
    logic [9:0]  backlog;
    logic [7:0]  drop_interval;
  } pacer_decision_t;

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT hookup
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;

  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  afp_in_if  ev_if ();
  afp_out_if res_if ();

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  adaptive_frame_pacer_unit #(
    .MAX_PENDING (MAX_PENDING)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (ev_if),
    .out_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Bench state
  // ---------------------------------------------------------------------------
  pacer_cmd_t      cmd_q[$];       // commands waiting for the driver
  pacer_decision_t decision_q[$];  // predicted results, oldest first

  bit          idle_on;      // random gaps / stalls allowed
  bit          ev_taken;     // set at the edge the current command was accepted
  int          src_gap;
  int          sink_gap;
  int unsigned useful_cnt;   // accepted commands the block actually acts on
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;

  // Shadow registers
  logic [15:0] reg_period;
  logic [7:0]  reg_tick;
  logic        reg_rtm;

  // Shadow pacing state
  int          pace_slack;     // signed Q24.8 ms: elapsed minus exact deadline
  int unsigned pace_pending;
  int unsigned pace_backlog;
  int unsigned pace_rendered;  // wraps at 32 bits
  int unsigned pace_interval;  // 0 = dropping off
  logic [3:0]  pace_quiet;

  // ---------------------------------------------------------------------------
  // Pacing predictor
  // ---------------------------------------------------------------------------
  // Slack after a restart: minus the frame period rounded half up to whole ms,
  // kept in Q8.
  function automatic int slack_after_reload(input logic [15:0] period);
    int unsigned whole_ms;
    whole_ms = (32'(period) + 32'd128) >> 8;
    return -int'(whole_ms << 8);
  endfunction

  // Advances the shadow state by one command and returns the decision the
  // block must report. 'counted' is low for commands the block just ignores.
  function automatic pacer_decision_t pace_event(input logic [1:0] cmd,
                                                 input logic [6:0] pct,
                                                 output bit counted);
    pacer_decision_t res;
    longint          acc;
    int unsigned     nxt;
    int unsigned     left;
    bit              skip;
    res.action    = ACT_NONE;
    res.frame_due = 1'b0;
    counted       = 1'b1;
    case (cmd)
      CMD_TICK: begin
        if (!reg_rtm) begin
          counted = 1'b0;          // ticks do nothing outside real-time mode
        end else begin
          acc = longint'(pace_slack) + longint'(reg_tick) * 256;
          if (acc > 64'sd2147483647) acc = 64'sd2147483647;
          if (acc < -127) begin
            pace_slack = int'(acc);
          end else begin
            // deadline crossed: at most one frame per tick
            acc = acc - longint'(reg_period);
            pace_slack    = int'(acc);
            pace_backlog  = pace_pending;
            if (pace_pending < MAX_PENDING) pace_pending++;
            res.frame_due = 1'b1;
          end
        end
      end
      CMD_SLOT: begin
        if (reg_rtm && pace_pending == 0) begin
          counted = 1'b0;          // nothing to render
        end else begin
          if (reg_rtm) pace_pending--;
          pace_quiet = pace_quiet + 4'd1;
          if (pace_quiet >= 4'd8 && pace_interval != 0) begin
            // relax by 5%, at least one step; past 200 dropping switches off
            nxt = (pace_interval * 105 + 50) / 100;
            if (nxt == pace_interval) nxt++;
            pace_interval = (nxt > 200) ? 0 : nxt;
            pace_quiet    = 4'd0;
          end
          skip = 1'b0;
          if (pace_backlog > 2) begin
            skip = 1'b1;
          end else begin
            if (pace_interval != 0) begin
              left = pace_rendered % pace_interval;
              skip = (left == pace_interval - 1) || (left == pace_interval / 2);
            end
            pace_rendered++;
          end
          res.action = (skip && reg_rtm) ? ACT_SKIP : ACT_RENDER;
        end
      end
      CMD_DROP: begin
        if (pct == 7'd0) begin
          counted = 1'b0;
        end else begin
          pace_quiet = 4'd0;
          if (pace_interval == 0) begin
            pace_interval = 200;
          end else if (pace_interval > 3) begin
            nxt = (pace_interval * 96 + 50) / 100;
            pace_interval = (nxt < 3) ? 3 : nxt;
          end
        end
      end
      default: counted = 1'b0;     // spare command code
    endcase
    res.backlog       = 10'(pace_backlog);
    res.drop_interval = 8'(pace_interval);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Command driver: launches on the falling edge, holds until accepted
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    pacer_cmd_t nxt;
    if (rst_n && (!ev_if.valid || ev_taken)) begin
      ev_taken = 1'b0;
      if (src_gap > 0) begin
        src_gap--;
        ev_if.valid <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        nxt = cmd_q.pop_front();
        ev_if.valid        <= 1'b1;
        ev_if.command      <= nxt.cmd;
        ev_if.drop_percent <= nxt.pct;
        // occasional gap after this transaction
        if (idle_on && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 15);
      end else begin
        ev_if.valid <= 1'b0;
      end
    end
  end

  // Result sink: random stall bursts while idling is enabled
  always @(negedge clk) begin
    if (rst_n) begin
      if (idle_on && sink_gap > 0) begin
        sink_gap--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        if (idle_on && $urandom_range(0, 7) == 0) sink_gap = $urandom_range(1, 15);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on command acceptance, checks on result acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pacer_decision_t want;
    bit              counted;
    if (rst_n) begin
      if (ev_if.valid && ev_if.ready) begin
        want = pace_event(ev_if.command, ev_if.drop_percent, counted);
        decision_q.push_back(want);
        if (counted) useful_cnt++;
        ev_taken = 1'b1;
      end
      if (res_if.valid && res_if.ready) begin
        if (decision_q.size() == 0) begin
          $error("result transaction with nothing expected: action %0d", res_if.action);
          mismatch_cnt++;
        end else begin
          want = decision_q.pop_front();
          if (res_if.action !== want.action) begin
            $error("action: expected %0d, actual %0d", want.action, res_if.action);
            mismatch_cnt++;
          end
          if (res_if.frame_due !== want.frame_due) begin
            $error("frame_due: expected %0d, actual %0d", want.frame_due, res_if.frame_due);
            mismatch_cnt++;
          end
          if (res_if.backlog_seen !== want.backlog) begin
            $error("backlog_seen: expected %0d, actual %0d", want.backlog,
                   res_if.backlog_seen);
            mismatch_cnt++;
          end
          if (res_if.drop_interval_now !== want.drop_interval) begin
            $error("drop_interval_now: expected %0d, actual %0d", want.drop_interval,
                   res_if.drop_interval_now);
            mismatch_cnt++;
          end
        end
      end
    end
    cycle_cnt++;
    if (cycle_cnt >= RUN_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_cmd(input logic [1:0] cmd, input logic [6:0] pct);
    pacer_cmd_t c;
    c.cmd = cmd;
    c.pct = pct;
    cmd_q.push_back(c);
  endtask

  // Wait until the block has nothing in flight, then a margin for the
  // longest command latency.
  task automatic settle();
    while (cmd_q.size() != 0 || ev_if.valid || decision_q.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  // Register write; the shadow copy follows at the same time. Only called
  // while the block is idle.
  task automatic reg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      CFG_PERIOD: begin
        // period write restarts pacing
        reg_period    = data;
        pace_slack    = slack_after_reload(data);
        pace_rendered = 0;
      end
      CFG_TICK: reg_tick = data[7:0];
      CFG_RTM:  reg_rtm  = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // One configuration plus random traffic until n_useful commands that the
  // block acts on have been accepted. Most traffic is frame-shaped: enough
  // ticks to reach one deadline (capped at 16), then the slot that consumes it,
  // sometimes a drop request. The rest is loose drops, tick bursts that pile
  // up a backlog, slot bursts that drain it, and raw random commands.
  task automatic run_phase(input logic [15:0] period, input logic [7:0] tick,
                           input logic rtm, input int drop_odds, input int n_useful);
    int unsigned goal;
    int unsigned frame_ticks;
    int          pick;
    settle();
    reg_write(CFG_TICK, CfgDataW'(tick));
    reg_write(CFG_RTM, CfgDataW'(rtm));
    reg_write(CFG_PERIOD, period);
    frame_ticks = (32'(period) + 256 * 32'(tick) - 1) / (256 * 32'(tick));
    if (frame_ticks < 1)  frame_ticks = 1;
    if (frame_ticks > 16) frame_ticks = 16;
    goal = useful_cnt + n_useful;
    while (useful_cnt < goal) begin
      while (cmd_q.size() > QUEUE_DEPTH) @(posedge clk);
      // now and then let everything drain mid-phase
      if ($urandom_range(0, 149) == 0) settle();
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        repeat (frame_ticks) queue_cmd(CMD_TICK, 7'($urandom));
        queue_cmd(CMD_SLOT, 7'($urandom));
        if ($urandom_range(0, 99) < drop_odds) queue_cmd(CMD_DROP, 7'($urandom_range(1, 127)));
      end else if (pick < 82) begin
        queue_cmd(CMD_DROP, ($urandom_range(0, 3) == 0) ? 7'd0 : 7'($urandom_range(0, 127)));
      end else if (pick < 90) begin
        repeat ($urandom_range(3, 8) * frame_ticks) queue_cmd(CMD_TICK, 7'($urandom));
      end else if (pick < 96) begin
        repeat ($urandom_range(2, 8)) queue_cmd(CMD_SLOT, 7'($urandom));
      end else begin
        queue_cmd(2'($urandom), 7'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n              = 1'b0;
    ev_if.valid        = 1'b0;
    ev_if.command      = CMD_TICK;
    ev_if.drop_percent = 7'd0;
    res_if.ready       = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = CFG_PERIOD;
    cfg_data           = '0;
    idle_on            = 1'b0;
    ev_taken           = 1'b0;
    src_gap            = 0;
    sink_gap           = 0;
    useful_cnt         = 0;
    mismatch_cnt       = 0;
    cycle_cnt          = 0;

    // shadow of the reset state: 40 ms frames, 1 ms ticks, real-time mode
    reg_period    = 16'd10240;
    reg_tick      = 8'd1;
    reg_rtm       = 1'b1;
    pace_slack    = slack_after_reload(16'd10240);
    pace_pending  = 0;
    pace_backlog  = 0;
    pace_rendered = 0;
    pace_interval = 0;
    pace_quiet    = 4'd0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // --- directed: reset settings -------------------------------------------
    queue_cmd(CMD_SLOT, 7'd0);        // nothing pending: ignored
    queue_cmd(CMD_SPARE, 7'd127);     // spare command: ignored
    queue_cmd(CMD_DROP, 7'd0);        // zero-strength drop: no effect
    queue_cmd(CMD_DROP, 7'd100);      // dropping turns on at 200
    queue_cmd(CMD_DROP, 7'd1);        // tighten
    queue_cmd(CMD_TICK, 7'd0);        // far from a deadline

    // --- directed: longest period, longest tick ------------------------------
    settle();
    reg_write(CFG_TICK, CfgDataW'(8'd255));
    reg_write(CFG_PERIOD, 16'd65535);
    repeat (3) queue_cmd(CMD_TICK, 7'd0);
    repeat (2) queue_cmd(CMD_SLOT, 7'd0);

    // --- directed: free-running mode -----------------------------------------
    settle();
    reg_write(CFG_RTM, CfgDataW'(1'b0));
    queue_cmd(CMD_TICK, 7'd0);        // tick ignored
    queue_cmd(CMD_SLOT, 7'd0);        // always renders, takes nothing
    queue_cmd(CMD_DROP, 7'd127);

    // --- directed: shortest period, a deadline on every tick -----------------
    settle();
    reg_write(CFG_RTM, CfgDataW'(1'b1));
    reg_write(CFG_TICK, CfgDataW'(8'd1));
    reg_write(CFG_PERIOD, 16'd1);
    reg_write(CFG_SPARE, 16'hFFFF);   // no such register: must change nothing
    repeat (4) queue_cmd(CMD_TICK, 7'd0);
    repeat (3) queue_cmd(CMD_SLOT, 7'd0);

    // --- random phases with gaps and stalls ----------------------------------
    idle_on = 1'b1;
    run_phase(16'd1024, 8'd1, 1'b1, 15, 200);
    run_phase(16'd700, 8'd2, 1'b1, 90, 250);    // drop-heavy: small intervals
    run_phase(16'($urandom_range(1, 65535)), 8'($urandom_range(1, 255)), 1'b1, 20, 160);
    run_phase(16'd65535, 8'd255, 1'b1, 10, 120);
    run_phase(16'd300, 8'd1, 1'b0, 20, 120);    // free-running
    run_phase(16'd10240, 8'd40, 1'b1, 15, 160);
    run_phase(16'($urandom_range(256, 4000)), 8'($urandom_range(1, 4)), 1'b1,
              $urandom_range(5, 60), 200);

    // --- last part: full rate, no gaps or stalls -----------------------------
    idle_on = 1'b0;
    run_phase(16'd512, 8'd1, 1'b1, 25, 120);

    // Soak: 1/256 ms frames against 255 ms ticks. Every tick crosses a
    // deadline, the backlog climbs and the occasional slot is forced to skip.
    settle();
    reg_write(CFG_TICK, CfgDataW'(8'd255));
    reg_write(CFG_PERIOD, 16'd1);
    for (int i = 0; i < SOAK_TICKS; i++) begin
      while (cmd_q.size() > QUEUE_DEPTH) @(posedge clk);
      queue_cmd(CMD_TICK, 7'($urandom));
      if (i % 16 == 15) queue_cmd(CMD_SLOT, 7'($urandom));
    end

    settle();
    if (mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/afp_pkg.sv
rtl/afp_in_if.sv
rtl/afp_out_if.sv
rtl/afp_div.sv
rtl/adaptive_frame_pacer_unit.sv
tb/tb_top.sv
